// File: rtl/mvbr_pkg.sv
// Shared types and constants for the majority-vote bit resampler.
// No dependencies; used by every module of the block.
package mvbr_pkg;

    localparam int MAX_WINDOW  = 1024;
    localparam int SAMPLE_W    = 8;
    localparam int CFG_W       = 24;
    localparam int PHASE_W     = 25;
    localparam int COUNT_W     = 11;
    localparam int FRAC_BITS   = 14;

    localparam logic [PHASE_W-1:0] ONE_SAMPLE_Q14 = PHASE_W'(1 << FRAC_BITS);
    localparam logic [PHASE_W:0]   WIN_TOP_Q14    = (PHASE_W+1)'(MAX_WINDOW * (1 << FRAC_BITS));
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic CFG_WINDOW_LEN = 1'b0;
    localparam logic CFG_MARGIN     = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3069000);
    localparam logic [CFG_W-1:0] MARGIN_RESET = CFG_W'(306900);

    typedef struct packed {
        logic decided_bit;
        logic lock_lost;
    } t_result;

endpackage

// File: rtl/mvbr_core.sv
// Lock tracking, vote counting and window phase for the resampler.
// Depends on mvbr_pkg; state advances once for each word fired in.
module mvbr_core import mvbr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [CFG_W-1:0]    i_window_len_q14,
    input  logic [CFG_W-1:0]    i_unlock_margin_q14,
    output logic                o_has_result,
    output t_result             o_result
);

    logic                r_locked,     n_locked;
    logic                r_prev_valid;
    logic [SAMPLE_W-1:0] r_prev_sample;
    logic [PHASE_W-1:0]  r_phase,      n_phase;
    logic [COUNT_W-1:0]  r_ones,       n_ones;
    logic [COUNT_W-1:0]  r_zeros,      n_zeros;

    logic               go;
    logic [COUNT_W-1:0] ones_cnt, zeros_cnt, diff;
    logic [PHASE_W:0]   win_eff, ph, ph_wrap;
    logic               hit, lost;

    always_comb begin
        // Clamp the window to [one sample, MAX_WINDOW samples]
        win_eff = {{(PHASE_W+1-CFG_W){1'b0}}, i_window_len_q14};
        if (win_eff < {1'b0, ONE_SAMPLE_Q14}) begin
            win_eff = {1'b0, ONE_SAMPLE_Q14};
        end
        if (win_eff > WIN_TOP_Q14) begin
            win_eff = WIN_TOP_Q14;
        end

        go = r_locked || (r_prev_valid && (i_sample != r_prev_sample));

        // A fresh lock starts from cleared counters and phase
        ones_cnt  = r_locked ? r_ones  : '0;
        zeros_cnt = r_locked ? r_zeros : '0;
        if (i_sample != '0) begin
            if (ones_cnt != COUNT_MAX) ones_cnt = ones_cnt + 1'b1;
        end else begin
            if (zeros_cnt != COUNT_MAX) zeros_cnt = zeros_cnt + 1'b1;
        end

        ph      = {1'b0, (r_locked ? r_phase : '0)} + {1'b0, ONE_SAMPLE_Q14};
        hit     = go && (ph >= win_eff);
        ph_wrap = ph - win_eff;

        diff = (ones_cnt > zeros_cnt) ? (ones_cnt - zeros_cnt) : (zeros_cnt - ones_cnt);
        lost = {diff, {FRAC_BITS{1'b0}}} < {1'b0, i_unlock_margin_q14};

        o_has_result         = hit;
        o_result.decided_bit = ones_cnt > zeros_cnt;
        o_result.lock_lost   = lost;

        n_locked = go && !(hit && lost);
        n_phase  = r_phase;
        n_ones   = r_ones;
        n_zeros  = r_zeros;
        if (go) begin
            n_phase = hit ? ph_wrap[PHASE_W-1:0] : ph[PHASE_W-1:0];
            n_ones  = hit ? '0 : ones_cnt;
            n_zeros = hit ? '0 : zeros_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked      <= 1'b0;
            r_prev_valid  <= 1'b0;
            r_prev_sample <= '0;
            r_phase       <= '0;
            r_ones        <= '0;
            r_zeros       <= '0;
        end else if (i_fire) begin
            r_locked      <= n_locked;
            r_prev_valid  <= 1'b1;
            r_prev_sample <= i_sample;
            r_phase       <= n_phase;
            r_ones        <= n_ones;
            r_zeros       <= n_zeros;
        end
    end

endmodule

// File: rtl/majority_vote_bit_resampler.sv
// Datapath: a sample word waits in the input register r_in_sample; a decision
// it closes is registered in r_out. Throughput: one sample word per cycle; the
// input stage holds only while a decision is waiting on a stalled output register.
// Reset: synchronous, active low; clears lock, counters, phase and valids,
// and loads the default window and margin registers.
module majority_vote_bit_resampler import mvbr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_decided_bit,
    output logic                o_lock_lost,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    logic [CFG_W-1:0]    r_window_len_q14;
    logic [CFG_W-1:0]    r_unlock_margin_q14;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;

    logic    fire, has_result;
    t_result result;

    // Fire unless a decision would land on a full, stalled output register
    assign fire        = r_in_valid && (!has_result || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_decided_bit = r_out.decided_bit;
    assign o_lock_lost   = r_out.lock_lost;

    mvbr_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (fire),
        .i_sample            (r_in_sample),
        .i_window_len_q14    (r_window_len_q14),
        .i_unlock_margin_q14 (r_unlock_margin_q14),
        .o_has_result        (has_result),
        .o_result            (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len_q14    <= WINDOW_RESET;
            r_unlock_margin_q14 <= MARGIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LEN: r_window_len_q14    <= i_cfg_data;
                CFG_MARGIN:     r_unlock_margin_q14 <= i_cfg_data;
                default:        r_window_len_q14    <= r_window_len_q14;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            r_out <= result;
        end
    end

endmodule

// File: rtl/mvbr_checker.sv
// Port-level checks for the majority-vote bit resampler, bound to the top.
// Depends on mvbr_pkg and the top level's ports.
module mvbr_checker import mvbr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic                o_decided_bit,
    input  logic                o_lock_lost
);

    // A stalled result word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_decided_bit) && $stable(o_lock_lost))
        else $error("result word changed under stall");

    // A stalled sample word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_sample))
        else $error("sample word changed under stall");

    // Input holds only behind a stalled result word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // A new result word follows an accepted sample through the input and output registers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result word without a matching sample");

endmodule

bind majority_vote_bit_resampler mvbr_checker u_mvbr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_sample      (i_sample),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_decided_bit (o_decided_bit),
    .o_lock_lost   (o_lock_lost)
);

// File: test/majority_vote_bit_resampler_tb.sv
// Self-checking testbench for majority_vote_bit_resampler: drives oversampled chip
// streams, predicts each majority decision and compares every result word.
// Depends on mvbr_pkg and the majority_vote_bit_resampler RTL.
module majority_vote_bit_resampler_tb;
    import mvbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int IDLE_PCT       = 18;
    localparam int NOISE_PCT      = 12;

    // Predicts decisions from accepted sample words and checks result words in order.
    class decision_tracker;
        logic [CFG_W-1:0]    window_q14;
        logic [CFG_W-1:0]    margin_q14;
        bit                  locked;
        bit                  have_prev;
        logic [SAMPLE_W-1:0] last_sample;
        logic [PHASE_W-1:0]  phase_q14;
        logic [COUNT_W-1:0]  ones_cnt;
        logic [COUNT_W-1:0]  zeros_cnt;
        t_result             pending_decisions[$];
        int unsigned         errors;

        function new();
            window_q14  = WINDOW_RESET;
            margin_q14  = MARGIN_RESET;
            locked      = 1'b0;
            have_prev   = 1'b0;
            last_sample = '0;
            phase_q14   = '0;
            ones_cnt    = '0;
            zeros_cnt   = '0;
            errors      = 0;
        endfunction

        function void note_config(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_WINDOW_LEN)
                window_q14 = value;
            else
                margin_q14 = value;
        endfunction

        function int pending();
            return pending_decisions.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [PHASE_W:0]   win;
            logic [PHASE_W:0]   ph;
            logic [COUNT_W-1:0] diff;
            t_result            r;
            if (!locked) begin
                // lock on the first change of the whole byte
                if (have_prev && s != last_sample) begin
                    locked    = 1'b1;
                    phase_q14 = '0;
                    ones_cnt  = '0;
                    zeros_cnt = '0;
                end else begin
                    last_sample = s;
                    have_prev   = 1'b1;
                    return;
                end
            end
            if (s != '0) begin
                if (ones_cnt != COUNT_MAX)
                    ones_cnt = ones_cnt + 1'b1;
            end else begin
                if (zeros_cnt != COUNT_MAX)
                    zeros_cnt = zeros_cnt + 1'b1;
            end
            // clamp the window to one sample at the bottom and the maximum at the top
            win = (PHASE_W+1)'(window_q14);
            if (win < (PHASE_W+1)'(ONE_SAMPLE_Q14))
                win = (PHASE_W+1)'(ONE_SAMPLE_Q14);
            if (win > WIN_TOP_Q14)
                win = WIN_TOP_Q14;
            ph = {1'b0, phase_q14} + {1'b0, ONE_SAMPLE_Q14};
            if (ph >= win) begin
                ph   = ph - win;
                diff = (ones_cnt > zeros_cnt) ? ones_cnt - zeros_cnt : zeros_cnt - ones_cnt;
                r.decided_bit = (ones_cnt > zeros_cnt);
                if ({diff, {FRAC_BITS{1'b0}}} < {1'b0, margin_q14}) begin
                    locked      = 1'b0;
                    r.lock_lost = 1'b1;
                end else begin
                    r.lock_lost = 1'b0;
                end
                ones_cnt  = '0;
                zeros_cnt = '0;
                pending_decisions.push_back(r);
            end
            phase_q14   = ph[PHASE_W-1:0];
            last_sample = s;
            have_prev   = 1'b1;
        endfunction

        function void check_decision(logic got_bit, logic got_lost);
            t_result want;
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected result word: decided_bit=%0b lock_lost=%0b",
                         $time, got_bit, got_lost);
                errors++;
                return;
            end
            want = pending_decisions.pop_front();
            if (got_bit !== want.decided_bit) begin
                $display("%0t: decided_bit mismatch: expected %0b, actual %0b",
                         $time, want.decided_bit, got_bit);
                errors++;
            end
            if (got_lost !== want.lock_lost) begin
                $display("%0t: lock_lost mismatch: expected %0b, actual %0b",
                         $time, want.lock_lost, got_lost);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [SAMPLE_W-1:0] i_sample    = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_decided_bit;
    logic                o_lock_lost;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = CFG_WINDOW_LEN;
    logic [CFG_W-1:0]    i_cfg_data  = '0;

    decision_tracker tracker;
    bit              steady = 1'b0;
    int              quiet_cycles = 0;

    majority_vote_bit_resampler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_decided_bit (o_decided_bit),
        .o_lock_lost   (o_lock_lost),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Note accepted words, check results and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            tracker.note_sample(i_sample);
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_decision(o_decided_bit, o_lock_lost);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Leaves valid high; the caller drops it.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tracker.note_config(idx, value);
        @(negedge i_clk);
    endtask

    // Drain every expected decision, then allow for words still in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Oversampled random bit stream: each bit held for about spb samples,
    // with byte noise and the odd bit of random length to break alignment.
    task automatic play_chips(input int unsigned count, input int unsigned spb);
        int unsigned         left;
        logic [SAMPLE_W-1:0] level;
        left  = 0;
        level = '0;
        repeat (count) begin
            if (left == 0) begin
                level = $urandom_range(1) ? SAMPLE_W'($urandom_range(255, 1))
                                          : {SAMPLE_W{1'b0}};
                left  = ($urandom_range(9) == 0) ? $urandom_range(spb + 1, 1) : spb;
            end
            left--;
            if ($urandom_range(99) < NOISE_PCT)
                send_sample(SAMPLE_W'($urandom_range(255)));
            else
                send_sample(level);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] margin,
                             input int unsigned count, input bit no_idle);
        int unsigned spb;
        settle();
        write_reg(CFG_WINDOW_LEN, win);
        write_reg(CFG_MARGIN, margin);
        i_cfg_valid <= 1'b0;
        spb = (int'(win) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (spb == 0)
            spb = 1;
        steady = no_idle;
        play_chips(count, spb);
        steady = 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] win;
        tracker = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first sample, repeats that must not lock, then the locking change
        send_sample(8'h00);
        send_sample(8'h00);
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'h01);
        send_sample(8'h80);
        send_sample(8'h00);
        send_sample(8'h7F);
        send_sample(8'hFE);
        send_sample(8'h55);
        send_sample(8'hAA);
        send_sample(8'hFF);

        // carry on at the reset window and margin
        play_chips(200, (int'(WINDOW_RESET) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);

        // window below one sample: a decision on every locked sample
        run_phase(24'd0, 24'd0, 25, 1'b0);
        // largest margin: every decision drops lock
        run_phase(24'd16384, 24'hFFFFFF, 25, 1'b0);
        run_phase(24'd54152, 24'd32768, 60, 1'b1);
        // largest window, then a short one while the phase is still high
        run_phase(24'hFFFFFF, 24'd819200, 110, 1'b0);
        run_phase(24'd32768, 24'd16384, 40, 1'b1);
        repeat (4) begin
            win = CFG_W'($urandom_range(16384 * 12, 16384));
            run_phase(win, CFG_W'($urandom_range(win / 2)), 20, 1'b0);
        end
        settle();

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mvbr_pkg.sv
rtl/mvbr_core.sv
rtl/majority_vote_bit_resampler.sv
rtl/mvbr_checker.sv
test/majority_vote_bit_resampler_tb.sv
